/* sv/dcd_pkg.sv */
`default_nettype none

package dcd_pkg;

  localparam int unsigned DayCountBits = 16;
  localparam int unsigned EpochYear    = 1980;

  // Weekday of 1 January of the epoch year, Sunday = 0
  localparam int unsigned EpochWeekday =
    (1 + 5 * ((EpochYear - 1) % 4) + 4 * ((EpochYear - 1) % 100)
     + 6 * ((EpochYear - 1) % 400)) % 7;

  // Weekday of the day before the epoch day (day count zero)
  localparam int unsigned WeekdayBase = (EpochWeekday + 6) % 7;

  localparam int unsigned YearSpan    = EpochYear + (2 ** DayCountBits) / 365 + 1;
  localparam int unsigned YearBitsRaw = $clog2(YearSpan + 1);
  localparam int unsigned YearBits    = (YearBitsRaw > 12) ? YearBitsRaw : 12;

  localparam int unsigned EpochMod4   = EpochYear % 4;
  localparam int unsigned EpochMod100 = EpochYear % 100;
  localparam int unsigned EpochMod400 = EpochYear % 400;

  localparam logic [3:0] MonthJan = 4'd0;
  localparam logic [3:0] MonthFeb = 4'd1;
  localparam logic [3:0] MonthDec = 4'd11;

  // Non-leap length of a zero-based month
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    unique case (m)
      4'd1:                      len = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Reduce a value below 42 modulo 7
  function automatic logic [2:0] mod7(input logic [5:0] v);
    logic [5:0] r;
    priority if (v >= 6'd35) r = v - 6'd35;
    else if (v >= 6'd28)     r = v - 6'd28;
    else if (v >= 6'd21)     r = v - 6'd21;
    else if (v >= 6'd14)     r = v - 6'd14;
    else if (v >= 6'd7)      r = v - 6'd7;
    else                     r = v;
    return r[2:0];
  endfunction

endpackage

`default_nettype wire

/* sv/day_count_to_calendar_date_core.sv */
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid_i/in_ready_o  | days_since_epoch_i
// out     | output    | out_valid_o/out_ready_i| year_o, day_of_year_o, month_o,
//         |           |                        | day_of_month_o, day_of_week_o
//
// Per transaction, the whole years (up to 179) and the whole months (up to 11)
// are removed one per cycle by a single shared subtract/compare unit.
// The input side reopens once the result is loaded into the output register, so a
// new transaction can start while the previous result still waits.
// rst_ni clears the sequencer and the output valid; payload registers are not reset.
// A stalled output holds the finish step until the output register frees up.
`default_nettype none

module day_count_to_calendar_date_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [dcd_pkg::DayCountBits-1:0] days_since_epoch_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [11:0]                           year_o,
  output logic [8:0]                            day_of_year_o,
  output logic [3:0]                            month_o,
  output logic [4:0]                            day_of_month_o,
  output logic [2:0]                            day_of_week_o
);

  localparam int unsigned DW = dcd_pkg::DayCountBits;
  localparam int unsigned YW = dcd_pkg::YearBits;

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StYear   = 2'd1;
  localparam logic [1:0] StMonth  = 2'd2;
  localparam logic [1:0] StFinish = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [DW-1:0] days_q, days_d;
  logic [YW-1:0] year_q, year_d;
  logic [1:0]    y4_q, y4_d;
  logic [6:0]    y100_q, y100_d;
  logic [8:0]    y400_q, y400_d;
  logic [8:0]    doy_q, doy_d;
  logic [3:0]    mon_q, mon_d;
  logic [2:0]    wd_q, wd_d;

  logic          out_valid_q, out_valid_d;
  logic [11:0]   year_out_q;
  logic [8:0]    doy_out_q;
  logic [3:0]    mon_out_q;
  logic [4:0]    dom_out_q;
  logic [2:0]    dow_out_q;

  logic          leap;
  logic [8:0]    ylen;
  logic [4:0]    mlen;
  logic [8:0]    sub_len;
  logic [DW-1:0] sub_len_ext;
  logic [DW-1:0] diff;
  logic          fits;
  logic          load_out;
  logic          in_fire;

  assign leap = (y400_q == 9'd0) || ((y100_q != 7'd0) && (y4_q == 2'd0));
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = dcd_pkg::month_len(mon_q) +
                {4'd0, (mon_q == dcd_pkg::MonthFeb) && leap};

  // Shared subtract/compare unit for years and months
  assign sub_len     = (state_q == StYear) ? ylen : {4'd0, mlen};
  assign sub_len_ext = {{(DW-9){1'b0}}, sub_len};
  assign fits        = days_q <= sub_len_ext;
  assign diff        = days_q - sub_len_ext;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign load_out   = (state_q == StFinish) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    days_d  = days_q;
    year_d  = year_q;
    y4_d    = y4_q;
    y100_d  = y100_q;
    y400_d  = y400_q;
    doy_d   = doy_q;
    mon_d   = mon_q;
    wd_d    = wd_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d = StYear;
          days_d  = days_since_epoch_i;
          year_d  = YW'(dcd_pkg::EpochYear);
          y4_d    = 2'(dcd_pkg::EpochMod4);
          y100_d  = 7'(dcd_pkg::EpochMod100);
          y400_d  = 9'(dcd_pkg::EpochMod400);
          wd_d    = 3'(dcd_pkg::WeekdayBase);
          mon_d   = dcd_pkg::MonthJan;
        end
      end
      StYear: begin
        if (fits) begin
          state_d = StMonth;
          doy_d   = days_q[8:0];
        end else begin
          days_d = diff;
          year_d = year_q + YW'(1);
          y4_d   = y4_q + 2'd1;
          y100_d = (y100_q == 7'd99) ? 7'd0 : y100_q + 7'd1;
          y400_d = (y400_q == 9'd399) ? 9'd0 : y400_q + 9'd1;
          // 365 days advance the weekday by one, 366 by two
          wd_d   = dcd_pkg::mod7({3'd0, wd_q} + (leap ? 6'd2 : 6'd1));
        end
      end
      StMonth: begin
        if (fits || mon_q == dcd_pkg::MonthDec) begin
          state_d = StFinish;
        end else begin
          days_d = diff;
          mon_d  = mon_q + 4'd1;
          wd_d   = dcd_pkg::mod7({3'd0, wd_q} + {1'b0, mlen});
        end
      end
      StFinish: begin
        if (load_out) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    days_q <= days_d;
    year_q <= year_d;
    y4_q   <= y4_d;
    y100_q <= y100_d;
    y400_q <= y400_d;
    doy_q  <= doy_d;
    mon_q  <= mon_d;
    wd_q   <= wd_d;
    if (load_out) begin
      year_out_q <= year_q[11:0];
      doy_out_q  <= doy_q;
      mon_out_q  <= mon_q + 4'd1;
      dom_out_q  <= days_q[4:0];
      dow_out_q  <= dcd_pkg::mod7({3'd0, wd_q} + {1'b0, days_q[4:0]});
    end
  end

  assign out_valid_o    = out_valid_q;
  assign year_o         = year_out_q;
  assign day_of_year_o  = doy_out_q;
  assign month_o        = mon_out_q;
  assign day_of_month_o = dom_out_q;
  assign day_of_week_o  = dow_out_q;

  a_start_year: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == StYear)
    else $error("accepted transaction did not start the year loop");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMonth || state_q == StFinish) |-> mon_q <= dcd_pkg::MonthDec)
    else $error("month index out of range");

  a_doy_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StMonth |-> days_q <= DW'(366))
    else $error("day of year exceeds year length after year loop");

  a_wd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> wd_q <= 3'd6)
    else $error("weekday accumulator out of range");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_q && state_q == StIdle)
    else $error("finished result not presented");

endmodule

`default_nettype wire

/* sim/tb_day_count_to_calendar_date_core.sv */
`default_nettype none

module tb_day_count_to_calendar_date_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CountBits = dcd_pkg::DayCountBits;
  localparam int unsigned FirstYear = dcd_pkg::EpochYear;
  // Weekday of 1 January of the first year, Sunday = 0
  localparam int unsigned FirstWeekday =
    (1 + 5 * ((FirstYear - 1) % 4) + 4 * ((FirstYear - 1) % 100)
     + 6 * ((FirstYear - 1) % 400)) % 7;
  localparam int unsigned RandomItems = 550;
  localparam int unsigned MaxGap      = 14;
  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned DrainCycles = 250;
  localparam int unsigned YearsKept   = 180;

  typedef struct packed {
    logic [11:0] year;
    logic [8:0]  day_of_year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [2:0]  day_of_week;
  } cal_date_t;

  class calendar_scoreboard;
    cal_date_t   pending_dates[$];
    int unsigned month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    int unsigned converted = 0;
    int unsigned checked   = 0;
    int unsigned errors    = 0;
    int unsigned leap_days = 0;
    int unsigned min_year  = 32'hFFFF_FFFF;
    int unsigned max_year  = 0;

    static function bit is_leap_year(int unsigned y);
      return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function cal_date_t date_of_count(logic [CountBits-1:0] count);
      cal_date_t   d;
      int unsigned days;
      int unsigned yr;
      int unsigned ylen;
      int unsigned mon;
      int unsigned mlen;
      bit          lp;
      days = count;
      yr   = FirstYear;
      ylen = is_leap_year(yr) ? 366 : 365;
      // strip whole years
      while (days > ylen) begin
        days -= ylen;
        yr++;
        ylen = is_leap_year(yr) ? 366 : 365;
      end
      d.year        = yr[11:0];
      d.day_of_year = days[8:0];
      lp  = is_leap_year(yr);
      mon = 0;
      // strip whole months; December takes whatever is left
      forever begin
        mlen = month_days[mon] + ((mon == 1 && lp) ? 1 : 0);
        if (days <= mlen || mon >= 11) break;
        days -= mlen;
        mon++;
      end
      d.month        = 4'(mon + 1);
      d.day_of_month = days[4:0];
      d.day_of_week  = 3'(((count % 7) + FirstWeekday + 6) % 7);
      return d;
    endfunction

    function void note_day_count(logic [CountBits-1:0] count);
      pending_dates.push_back(date_of_count(count));
      converted++;
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_date(cal_date_t got);
      cal_date_t want;
      if (pending_dates.size() == 0) begin
        $error("result with no day count outstanding: %0d-%0d-%0d",
               got.year, got.month, got.day_of_month);
        errors++;
        return;
      end
      want = pending_dates.pop_front();
      checked++;
      compare_field("year", want.year, got.year);
      compare_field("day_of_year", want.day_of_year, got.day_of_year);
      compare_field("month", want.month, got.month);
      compare_field("day_of_month", want.day_of_month, got.day_of_month);
      compare_field("day_of_week", want.day_of_week, got.day_of_week);
      if (want.month == 2 && want.day_of_month == 29) leap_days++;
      if (want.year < min_year) min_year = want.year;
      if (want.year > max_year) max_year = want.year;
    endfunction

    function int unsigned pending();
      return pending_dates.size();
    endfunction
  endclass

  logic                 clk_i              = 1'b0;
  logic                 rst_ni             = 1'b0;
  logic                 in_valid_i         = 1'b0;
  logic                 in_ready_o;
  logic [CountBits-1:0] days_since_epoch_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i        = 1'b0;
  logic [11:0]          year_o;
  logic [8:0]           day_of_year_o;
  logic [3:0]           month_o;
  logic [4:0]           day_of_month_o;
  logic [2:0]           day_of_week_o;

  calendar_scoreboard calendar_sb = new();
  bit                 sender_rush   = 1'b0;
  bit                 receiver_rush = 1'b0;
  int unsigned        idle_cycles   = 0;
  int unsigned        year_first[YearsKept];

  // Leap days of 1980, 2000 and the non-leap 2100, plus both ends of the range
  logic [CountBits-1:0] directed_counts[] = '{
    16'd0,     // zero count, below the legal range
    16'd1, 16'd2, 16'd31, 16'd32,
    16'd59, 16'd60, 16'd61,         // 28 Feb, 29 Feb, 1 Mar 1980
    16'd365, 16'd366, 16'd367,      // end of the first leap year
    16'd7305, 16'd7306,             // 31 Dec 1999, 1 Jan 2000
    16'd7365, 16'd7366,             // 29 Feb, 1 Mar 2000
    16'd43830, 16'd43831,           // 31 Dec 2099, 1 Jan 2100
    16'd43889, 16'd43890,           // 28 Feb, 1 Mar 2100
    16'd44195,                      // 31 Dec 2100
    16'd65534, 16'd65535,
    16'h5555, 16'hAAAA, 16'h8000
  };

  day_count_to_calendar_date_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .days_since_epoch_i (days_since_epoch_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .year_o             (year_o),
    .day_of_year_o      (day_of_year_o),
    .month_o            (month_o),
    .day_of_month_o     (day_of_month_o),
    .day_of_week_o      (day_of_week_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Watchdog: no transaction for %0d cycles", idle_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic send_day_count(input logic [CountBits-1:0] count);
    int unsigned gap;
    gap = sender_rush ? 0 : $urandom_range(0, MaxGap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    days_since_epoch_i <= count;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    calendar_sb.note_day_count(count);
  endtask

  // Hold the input side until every outstanding date has come back
  task automatic drain_pending();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (calendar_sb.pending() != 0);
  endtask

  initial begin
    int unsigned stall;
    int unsigned n_results;
    n_results = 0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (n_results % 40 == 0) receiver_rush = ($urandom_range(0, 3) == 0);
      stall = receiver_rush ? 0 : $urandom_range(0, MaxGap);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      calendar_sb.check_date({year_o, day_of_year_o, month_o, day_of_month_o,
                              day_of_week_o});
      n_results++;
    end
  end

  initial begin
    int unsigned k;
    int unsigned c;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    year_first[0] = 1;
    for (k = 1; k < YearsKept; k++) begin
      year_first[k] = year_first[k-1]
                    + (calendar_scoreboard::is_leap_year(FirstYear + k - 1) ? 366 : 365);
    end

    foreach (directed_counts[i]) send_day_count(directed_counts[i]);
    drain_pending();

    for (int i = 0; i < RandomItems; i++) begin
      if (i % 40 == 0) sender_rush = ($urandom_range(0, 3) == 0);
      if (i % 137 == 136) drain_pending();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: c = $urandom_range(0, (1 << CountBits) - 1);
        6, 7: begin
          // land on a year boundary or around the end of February
          k = $urandom_range(1, YearsKept - 1);
          case ($urandom_range(0, 2))
            0:       c = year_first[k] - 1;
            1:       c = year_first[k];
            default: c = year_first[k] + 58 + $urandom_range(0, 2);
          endcase
        end
        default: c = $urandom_range(1, 1500);
      endcase
      send_day_count(c[CountBits-1:0]);
    end

    drain_pending();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Converted %0d day counts (%0d directed, rest random), %0d dates compared",
             calendar_sb.converted, directed_counts.size(), calendar_sb.checked);
    $display("Years %0d to %0d reached, %0d results fell on 29 February",
             calendar_sb.min_year, calendar_sb.max_year, calendar_sb.leap_days);
    if (calendar_sb.errors == 0 && calendar_sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
